// ===== sv/sha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Constants and round functions shared by the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int WORD_W     = 32;
	localparam int BLOCK_WORDS = 16;
	localparam int ROUNDS     = 64;
	localparam int CHAIN_N    = 8;

	// Round constants.
	localparam logic [31:0] K_TABLE [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Initial hash values.
	localparam logic [31:0] IV_TABLE [CHAIN_N] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [31:0] word_t;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== sv/sha_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/sha256_stream_hash_top.sv =====
`timescale 1ns / 1ps
// A byte that fills a block starts a compression (a read-setup step, then
// 64 rounds at one round per cycle, then a chaining add).
// End of message takes one or two such compressions, then 8 digest beats.
// Throughput: one byte per cycle while a block fills; input stalls during
// each compression and while the digest is delivered.
// Reset: asynchronous; chaining words return to the initial values, counts clear.
// ----------------------------------------------------------------------------
// sha256_stream_hash_top
// SHA-256 over a byte stream; the message block is held in a word RAM.
// ----------------------------------------------------------------------------
module sha256_stream_hash_top
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] byte_valid
	input  logic        s_tlast,  // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] digest_word
	output logic        m_tlast   // last_word
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_ADD   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [1:0] PASS_DATA = 2'd0;
	localparam logic [1:0] PASS_PADA = 2'd1;
	localparam logic [1:0] PASS_PADB = 2'd2;

	logic [2:0]  state_q;
	logic [1:0]  pass_q;
	logic        eom_pend_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [23:0] acc_q;
	logic [5:0]  rnd_q;
	logic [2:0]  out_idx_q;
	word_t       chain_q [CHAIN_N];
	word_t       v_q [CHAIN_N];
	word_t       win_q [BLOCK_WORDS];

	logic        in_beat;
	logic        byte_in;
	logic        ram_we;
	logic [3:0]  ram_raddr;
	word_t       ram_rdata;
	word_t       part_word;
	word_t       src_word;
	word_t       w_cur;
	word_t       t1;
	word_t       t2;
	logic [3:0]  j;
	logic        len_here;

	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign byte_in  = in_beat && s_tuser;
	assign ram_we   = byte_in && (fill_q[1:0] == 2'd3);
	assign ram_raddr = (state_q == ST_ROUND) ? (rnd_q[3:0] + 4'd1) : 4'd0;

	sha_ram #(
		.WIDTH(WORD_W),
		.DEPTH(BLOCK_WORDS)
	) u_block_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[5:2]),
		.wdata ({acc_q, s_tdata}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Word that holds the pad byte, with the bytes not yet written to the RAM.
	always_comb begin
		unique case (fill_q[1:0])
			2'd0: part_word = {PAD_BYTE, 24'h0};
			2'd1: part_word = {acc_q[7:0], PAD_BYTE, 16'h0};
			2'd2: part_word = {acc_q[15:0], PAD_BYTE, 8'h0};
			default: part_word = {acc_q[23:0], PAD_BYTE};
		endcase
	end

	// Message word for the current round of the first sixteen.
	assign j = rnd_q[3:0];
	assign len_here = (pass_q == PASS_PADB) ||
		((pass_q == PASS_PADA) && (fill_q < 6'd56));
	always_comb begin
		src_word = ram_rdata;
		if (pass_q != PASS_DATA) begin
			if ((pass_q == PASS_PADA) && (j < fill_q[5:2])) begin
				src_word = ram_rdata;
			end else if ((pass_q == PASS_PADA) && (j == fill_q[5:2])) begin
				src_word = part_word;
			end else if (len_here && (j == 4'd14)) begin
				src_word = bits_q[63:32];
			end else if (len_here && (j == 4'd15)) begin
				src_word = bits_q[31:0];
			end else begin
				src_word = '0;
			end
		end
	end

	// Schedule word and round sums.
	always_comb begin
		if (rnd_q < 6'd16) begin
			w_cur = src_word;
		end else begin
			w_cur = win_q[0] + small_sigma0(win_q[1]) + win_q[9] + small_sigma1(win_q[14]);
		end
		t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ K_TABLE[rnd_q] + w_cur;
		t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// Control sequencer and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pass_q     <= PASS_DATA;
			eom_pend_q <= 1'b0;
			fill_q     <= '0;
			bits_q     <= '0;
			rnd_q      <= '0;
			out_idx_q  <= '0;
			for (int i = 0; i < CHAIN_N; i++) begin
				chain_q[i] <= IV_TABLE[i];
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (byte_in) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
						end
						if (byte_in && (fill_q == 6'd63)) begin
							pass_q     <= PASS_DATA;
							eom_pend_q <= s_tlast;
							state_q    <= ST_LOAD;
						end else if (s_tlast) begin
							pass_q  <= PASS_PADA;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < CHAIN_N; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					unique case (pass_q)
						PASS_DATA: begin
							if (eom_pend_q) begin
								eom_pend_q <= 1'b0;
								pass_q     <= PASS_PADA;
								state_q    <= ST_LOAD;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						PASS_PADA: begin
							if (fill_q < 6'd56) begin
								out_idx_q <= '0;
								state_q   <= ST_OUT;
							end else begin
								pass_q  <= PASS_PADB;
								state_q <= ST_LOAD;
							end
						end
						default: begin
							out_idx_q <= '0;
							state_q   <= ST_OUT;
						end
					endcase
				end
				ST_OUT: begin
					if (m_tready) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							fill_q  <= '0;
							bits_q  <= '0;
							pass_q  <= PASS_DATA;
							state_q <= ST_IDLE;
							for (int i = 0; i < CHAIN_N; i++) begin
								chain_q[i] <= IV_TABLE[i];
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working variables, schedule window and partial word.
	always_ff @(posedge clk) begin
		if (byte_in) begin
			acc_q <= {acc_q[15:0], s_tdata};
		end
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < CHAIN_N; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[BLOCK_WORDS - 1] <= w_cur;
		end
	end

	// Digest beats come straight from the chaining registers.
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = chain_q[out_idx_q];
	assign m_tlast  = (out_idx_q == 3'd7);

endmodule

// ===== sim/sha256_digest_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both stream channels of the hasher, computes the SHA-256 digest of
// every accepted message and compares each digest beat against it.
// ----------------------------------------------------------------------------
module sha256_digest_checker
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          words_pending
);

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} digest_beat_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] START_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0]  hash_h [8];
	logic [7:0]   msg_block [64];
	int unsigned  fill_bytes;
	logic [63:0]  msg_bits;
	digest_beat_t digest_queue [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One compression of msg_block into hash_h.
	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3];
		e = hash_h[4]; f = hash_h[5]; g = hash_h[6]; h = hash_h[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
		hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
	endtask

	task automatic restart_message();
		for (int i = 0; i < 8; i++)
			hash_h[i] = START_H[i];
		fill_bytes = 0;
		msg_bits = '0;
	endtask

	// Absorb one input beat; at end of message pad and queue the digest.
	task automatic absorb_beat(input logic [7:0] data, input logic has_byte, input logic eom);
		int unsigned pos;
		if (has_byte) begin
			msg_block[fill_bytes[5:0]] = data;
			msg_bits += 64'd8;
			fill_bytes++;
			if (fill_bytes == 64) begin
				compress();
				fill_bytes = 0;
			end
		end
		if (eom) begin
			pos = fill_bytes;
			msg_block[pos[5:0]] = PAD_BYTE;
			pos++;
			if (pos > 56) begin
				while (pos < 64) begin
					msg_block[pos[5:0]] = 8'h00;
					pos++;
				end
				compress();
				pos = 0;
			end
			while (pos < 56) begin
				msg_block[pos[5:0]] = 8'h00;
				pos++;
			end
			for (int i = 0; i < 8; i++)
				msg_block[63-i] = msg_bits[8*i +: 8];
			compress();
			for (int i = 0; i < 8; i++)
				digest_queue.push_back('{word: hash_h[i], last: (i == 7)});
			restart_message();
		end
	endtask

	// Sample both channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		digest_beat_t exp_beat;
		if (!arst_n) begin
			restart_message();
			digest_queue.delete();
			fail_count = 0;
		end else begin
			if (s_tvalid && s_tready)
				absorb_beat(s_tdata, s_tuser, s_tlast);
			if (m_tvalid && m_tready) begin
				if (digest_queue.size() == 0) begin
					$display("%0t: unexpected digest beat: expected none, actual %h last %b",
						$time, m_tdata, m_tlast);
					fail_count++;
				end else begin
					exp_beat = digest_queue.pop_front();
					if (m_tdata !== exp_beat.word) begin
						$display("%0t: digest word mismatch: expected %h, actual %h",
							$time, exp_beat.word, m_tdata);
						fail_count++;
					end
					if (m_tlast !== exp_beat.last) begin
						$display("%0t: last flag mismatch: expected %b, actual %b",
							$time, exp_beat.last, m_tlast);
						fail_count++;
					end
				end
			end
		end
		words_pending = digest_queue.size();
	end

endmodule

// ===== sim/tb_sha256_stream_hash_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_stream_hash_top
// Drives messages of many lengths into the hasher, with random gaps and
// stalls, and lets the digest checker judge every output beat.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hash_top;
	import sha_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	int          fail_count;
	int          words_pending;
	logic        calm = 1'b0;    // no idling on either side
	logic        hold_sink = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sha256_stream_hash_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	sha256_digest_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .words_pending(words_pending)
	);

	// Send one beat, with a random gap before it unless idling is off.
	// Valid stays up after the handshake; the next beat or a gap replaces it.
	task automatic send_beat(input logic [7:0] data, input logic has_byte, input logic eom);
		while (!calm && $urandom_range(99) < 22) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= has_byte;
		s_tlast  <= eom;
		do @(posedge clk); while (!s_tready);
	endtask

	// Send a message of len random bytes; eom_mode chooses how it ends.
	task automatic send_message(input int len, input int eom_mode);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(15) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom), 1'b1, (eom_mode == 0) && (i == len - 1));
		end
		if (eom_mode != 0 || len == 0)
			send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	// Receiver: random stalls, and a long hold-off on request.
	always @(posedge clk) begin
		if (hold_sink)
			m_tready <= 1'b0;
		else
			m_tready <= calm || ($urandom_range(99) >= 22);
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int lens [] = '{0, 3, 56, 64};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme byte values, then padding boundary lengths.
		// The two long messages run with no idling at all.
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hff, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'hff, 1'b0, 1'b1);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'hff, 1'b1, 1'b1);
		foreach (lens[i]) begin
			calm <= (lens[i] >= 56);
			send_message(lens[i], $urandom_range(1));
		end
		calm <= 1'b0;

		// Long hold-off on the receiver while messages keep coming.
		fork
			begin
				hold_sink <= 1'b1;
				repeat (400) @(posedge clk);
				hold_sink <= 1'b0;
			end
			begin
				send_message(3, 0);
				send_message(2, 1);
				send_message(5, 0);
			end
		join

		// Random short messages.
		for (int m = 0; m < 6; m++)
			send_message($urandom_range(10), $urandom_range(1));
		s_tvalid <= 1'b0;

		while (words_pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
